/* rtl/mpb_pkg.sv */
// Shared types and constants for the metronome pulse block.
// No dependencies; imported by every module of the block but the port-level checker.
`default_nettype none

package mpb_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MIN_TEMPO   = 3'd0,
    CFG_MAX_TEMPO   = 3'd1,
    CFG_START_TEMPO = 3'd2,
    CFG_SUB_PERIOD  = 3'd3,
    CFG_PULSE_ON    = 3'd4,
    CFG_REPEAT_INTV = 3'd5
  } cfg_idx_e;

  localparam logic [7:0]  MinTempoRst   = 8'd40;
  localparam logic [7:0]  MaxTempoRst   = 8'd240;
  localparam logic [7:0]  StartTempoRst = 8'd120;
  localparam logic [15:0] SubPeriodRst  = 16'd250;
  localparam logic [15:0] PulseOnRst    = 16'd100;
  localparam logic [9:0]  RepeatIntvRst = 10'd500;

  localparam logic [3:0] FastStepAfter = 4'd10;
  localparam logic [2:0] SlowStep      = 3'd1;
  localparam logic [2:0] FastStep      = 3'd5;

  typedef struct packed {
    logic [7:0]  min_tempo;
    logic [7:0]  max_tempo;
    logic [15:0] sub_period_ticks;
    logic [15:0] pulse_on_ticks;
    logic [9:0]  repeat_interval;
  } cfg_t;

  typedef struct packed {
    logic pulse;
    logic beat;
  } beat_stat_t;

endpackage

`default_nettype wire

/* rtl/mpb_beat.sv */
// Two-stage beat counter and pulse level register.
// Depends on mpb_pkg for cfg_t and beat_stat_t.
`default_nettype none

module mpb_beat
  import mpb_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       en_i,
  input  wire cfg_t       cfg_i,
  input  wire logic [7:0] tempo_i,
  output beat_stat_t      stat_d_o
);

  logic [15:0] tick_q, tick_d;
  logic [7:0]  sub_q, sub_d;
  logic        pulse_q, pulse_d;
  logic        beat_d;

  logic [16:0]        next_tick;
  logic signed [10:0] target;
  logic signed [10:0] next_sub;

  always_comb begin
    next_tick = {1'b0, tick_q} + 17'd1;
    target    = $signed({3'b000, cfg_i.max_tempo}) + 11'sd1
              - $signed({3'b000, tempo_i});
    next_sub  = $signed({3'b000, sub_q}) + 11'sd1;
    tick_d    = tick_q;
    sub_d     = sub_q;
    pulse_d   = pulse_q;
    beat_d    = 1'b0;
    if (next_tick >= {1'b0, cfg_i.sub_period_ticks}) begin
      tick_d = '0;
      if (next_sub >= target) begin
        sub_d   = '0;
        pulse_d = 1'b1;
        beat_d  = 1'b1;
      end else begin
        sub_d = next_sub[7:0];
      end
    end else begin
      tick_d = next_tick[15:0];
      if (tick_d == cfg_i.pulse_on_ticks) begin
        pulse_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q  <= '0;
      sub_q   <= '0;
      pulse_q <= 1'b0;
    end else if (en_i) begin
      tick_q  <= tick_d;
      sub_q   <= sub_d;
      pulse_q <= pulse_d;
    end
  end

  assign stat_d_o.pulse = pulse_d;
  assign stat_d_o.beat  = beat_d;

endmodule

`default_nettype wire

/* rtl/mpb_tempo.sv */
// Tempo register with button auto-repeat and clamping.
// Depends on mpb_pkg for cfg_t and step constants.
`default_nettype none

module mpb_tempo
  import mpb_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       en_i,
  input  wire cfg_t       cfg_i,
  input  wire logic       up_i,
  input  wire logic       down_i,
  output logic [7:0]      tempo_q_o,
  output logic [7:0]      tempo_d_o
);

  logic [7:0] tempo_q, tempo_d;
  logic       active_q, active_d;
  logic [9:0] rep_q, rep_d;
  logic [3:0] step_q, step_d;

  logic [10:0]       next_rep;
  logic [2:0]        mag;
  logic signed [9:0] sum;

  always_comb begin
    active_d = active_q | (up_i ^ down_i);
    rep_d    = rep_q;
    step_d   = step_q;
    tempo_d  = tempo_q;
    next_rep = {1'b0, rep_q} + 11'd1;
    mag      = (step_q < FastStepAfter) ? SlowStep : FastStep;
    sum      = $signed({2'b00, tempo_q});
    if (active_d) begin
      if (next_rep >= {1'b0, cfg_i.repeat_interval}) begin
        rep_d = '0;
        if (up_i) begin
          sum = $signed({2'b00, tempo_q}) + $signed({7'd0, mag});
        end else if (down_i) begin
          sum = $signed({2'b00, tempo_q}) - $signed({7'd0, mag});
        end
        if (up_i || down_i) begin
          if (step_q < FastStepAfter) begin
            step_d = step_q + 4'd1;
          end
        end else begin
          active_d = 1'b0;
          step_d   = '0;
        end
        if (sum > $signed({2'b00, cfg_i.max_tempo})) begin
          tempo_d = cfg_i.max_tempo;
        end else if (sum < $signed({2'b00, cfg_i.min_tempo})) begin
          tempo_d = cfg_i.min_tempo;
        end else begin
          tempo_d = sum[7:0];
        end
      end else begin
        rep_d = next_rep[9:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tempo_q  <= StartTempoRst;
      active_q <= 1'b0;
      rep_q    <= '0;
      step_q   <= '0;
    end else if (en_i) begin
      tempo_q  <= tempo_d;
      active_q <= active_d;
      rep_q    <= rep_d;
      step_q   <= step_d;
    end
  end

  assign tempo_q_o = tempo_q;
  assign tempo_d_o = tempo_d;

endmodule

`default_nettype wire

/* rtl/metronome_pulse_with_button_rate.sv */
// Top level of the metronome pulse generator with button tempo control.
// Depends on mpb_pkg, mpb_beat and mpb_tempo.
//
// Usage:
//  - Input channel (in_valid_i / in_stall_o): one transaction per 1 ms tick,
//    carrying the up and down button levels.
//  - Output channel (out_valid_o / out_stall_i): one transaction per tick with
//    the pulse pin level, current tempo and a beat start flag.
//  - Configuration: cfg_we_i writes register cfg_idx_i with cfg_wdata_i;
//    write only while idle. A start tempo write is accepted but reset always
//    reloads all registers, so the tempo returns to 120 at reset.
//  - Result: registered, it appears in the cycle after the input transaction.
//  - Throughput: one tick per cycle while the output is not stalled; all state
//    updates go through counter and compare logic into the result register.
//  - Reset: counters, pulse and repeat state clear, tempo loads 120 and the
//    configuration returns to its defaults; no result is pending.
//  - Stall: a pending result holds in the output register; a new tick is
//    taken only when that register is empty or being drained.
`default_nettype none

module metronome_pulse_with_button_rate
  import mpb_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                up_pressed_i,
  input  wire logic                down_pressed_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic                     pulse_level_o,
  output logic [7:0]               tempo_o,
  output logic                     beat_start_o
);

  cfg_t       cfg_q;
  logic       accept;
  logic       out_valid_q;
  logic       pulse_q, beat_q;
  logic [7:0] tempo_out_q;
  logic [7:0] tempo_cur;
  logic [7:0] tempo_nxt;
  beat_stat_t beat_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_tempo        <= MinTempoRst;
      cfg_q.max_tempo        <= MaxTempoRst;
      cfg_q.sub_period_ticks <= SubPeriodRst;
      cfg_q.pulse_on_ticks   <= PulseOnRst;
      cfg_q.repeat_interval  <= RepeatIntvRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MIN_TEMPO:   cfg_q.min_tempo        <= cfg_wdata_i[7:0];
        CFG_MAX_TEMPO:   cfg_q.max_tempo        <= cfg_wdata_i[7:0];
        CFG_START_TEMPO: ;
        CFG_SUB_PERIOD:  cfg_q.sub_period_ticks <= cfg_wdata_i;
        CFG_PULSE_ON:    cfg_q.pulse_on_ticks   <= cfg_wdata_i;
        CFG_REPEAT_INTV: cfg_q.repeat_interval  <= cfg_wdata_i[9:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  mpb_beat u_beat (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (accept),
    .cfg_i    (cfg_q),
    .tempo_i  (tempo_cur),
    .stat_d_o (beat_stat)
  );

  mpb_tempo u_tempo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (accept),
    .cfg_i     (cfg_q),
    .up_i      (up_pressed_i),
    .down_i    (down_pressed_i),
    .tempo_q_o (tempo_cur),
    .tempo_d_o (tempo_nxt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pulse_q     <= beat_stat.pulse;
      beat_q      <= beat_stat.beat;
      tempo_out_q <= tempo_nxt;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pulse_level_o = pulse_q;
  assign beat_start_o  = beat_q;
  assign tempo_o       = tempo_out_q;

endmodule

`default_nettype wire

/* rtl/mpb_checker.sv */
// Port-level checker for the metronome pulse block, bound to the top level.
// Watches the handshake and result ports only; no package dependencies.
`default_nettype none

module mpb_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic       pulse_level_o,
  input wire logic [7:0] tempo_o,
  input wire logic       beat_start_o
);

  // input only backs up behind a held result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> out_valid_o)
    else $error("accepted tick produced no result");

  a_beat_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && beat_start_o) |-> pulse_level_o)
    else $error("beat start without pulse high");

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled result dropped");

  a_hold_tempo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(tempo_o))
    else $error("stalled tempo changed");

endmodule

bind metronome_pulse_with_button_rate mpb_checker u_mpb_checker (.*);

`default_nettype wire

/* tb/sv/metronome_checker.sv */
// Checker for the metronome pulse block: mirrors the register writes, predicts
// each tick's pulse, tempo and beat flag, and compares every output transaction.
// Depends on mpb_pkg for the register indexes, reset values and step constants.
`timescale 1ns / 100ps

module metronome_checker
  import mpb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic                up_pressed_i,
  input  logic                down_pressed_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic                pulse_level_i,
  input  logic [7:0]          tempo_i,
  input  logic                beat_start_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  typedef struct packed {
    logic       pulse;
    logic [7:0] tempo;
    logic       beat;
  } tick_result_t;

  tick_result_t expected_ticks[$];

  cfg_t        cfg;
  logic [15:0] tick_cnt;
  logic [7:0]  sub_cnt;
  logic        pulse_q;
  logic [7:0]  tempo_q;
  logic        repeat_on;
  logic [9:0]  repeat_cnt;
  logic [3:0]  step_cnt;
  int          fails = 0;

  function automatic logic [7:0] clamp_tempo(input int t);
    if (t > int'(cfg.max_tempo)) return cfg.max_tempo;
    if (t < int'(cfg.min_tempo)) return cfg.min_tempo;
    return t[7:0];
  endfunction

  // one millisecond tick: beat counter on the old tempo, then auto-repeat
  task automatic advance_tick(input logic up, input logic down, output tick_result_t res);
    int   target;
    int   diff;
    int   mag;
    logic beat;
    beat = 1'b0;
    if (int'(tick_cnt) + 1 >= int'(cfg.sub_period_ticks)) begin
      target   = int'(cfg.max_tempo) + 1 - int'(tempo_q);
      tick_cnt = '0;
      if (int'(sub_cnt) + 1 >= target) begin
        sub_cnt = '0;
        pulse_q = 1'b1;
        beat    = 1'b1;
      end else begin
        sub_cnt = sub_cnt + 8'd1;
      end
    end else begin
      tick_cnt = tick_cnt + 16'd1;
      if (tick_cnt == cfg.pulse_on_ticks) pulse_q = 1'b0;
    end

    if (up != down) repeat_on = 1'b1;

    if (repeat_on) begin
      if (int'(repeat_cnt) + 1 >= int'(cfg.repeat_interval)) begin
        repeat_cnt = '0;
        diff       = 0;
        if (up || down) begin
          mag  = (step_cnt < FastStepAfter) ? int'(SlowStep) : int'(FastStep);
          diff = up ? mag : -mag;
          if (step_cnt < FastStepAfter) step_cnt = step_cnt + 4'd1;
        end else begin
          repeat_on = 1'b0;
          step_cnt  = '0;
        end
        tempo_q = clamp_tempo(int'(tempo_q) + diff);
      end else begin
        repeat_cnt = repeat_cnt + 10'd1;
      end
    end

    res.pulse = pulse_q;
    res.tempo = tempo_q;
    res.beat  = beat;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : tick_watch
    tick_result_t got;
    tick_result_t want;
    tick_result_t nxt;
    if (!rst_ni) begin
      cfg.min_tempo        = MinTempoRst;
      cfg.max_tempo        = MaxTempoRst;
      cfg.sub_period_ticks = SubPeriodRst;
      cfg.pulse_on_ticks   = PulseOnRst;
      cfg.repeat_interval  = RepeatIntvRst;
      tick_cnt   = '0;
      sub_cnt    = '0;
      pulse_q    = 1'b0;
      tempo_q    = StartTempoRst;
      repeat_on  = 1'b0;
      repeat_cnt = '0;
      step_cnt   = '0;
      expected_ticks.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got.pulse = pulse_level_i;
        got.tempo = tempo_i;
        got.beat  = beat_start_i;
        if (expected_ticks.size() == 0) begin
          if (fails < 10)
            $display("%0t: unexpected transaction pulse=%0b tempo=%0d beat=%0b",
                     $time, got.pulse, got.tempo, got.beat);
          fails++;
        end else begin
          want = expected_ticks.pop_front();
          if (got.pulse !== want.pulse || got.tempo !== want.tempo ||
              got.beat !== want.beat) begin
            if (fails < 10)
              $display({"%0t: mismatch exp pulse=%0b tempo=%0d beat=%0b, ",
                        "got pulse=%0b tempo=%0d beat=%0b"},
                       $time, want.pulse, want.tempo, want.beat,
                       got.pulse, got.tempo, got.beat);
            fails++;
          end
        end
      end

      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_MIN_TEMPO:   cfg.min_tempo        = cfg_wdata_i[7:0];
          CFG_MAX_TEMPO:   cfg.max_tempo        = cfg_wdata_i[7:0];
          CFG_SUB_PERIOD:  cfg.sub_period_ticks = cfg_wdata_i;
          CFG_PULSE_ON:    cfg.pulse_on_ticks   = cfg_wdata_i;
          CFG_REPEAT_INTV: cfg.repeat_interval  = cfg_wdata_i[9:0];
          default: ;  // start tempo only matters at reset
        endcase
      end

      if (in_valid_i && !in_stall_i) begin
        advance_tick(up_pressed_i, down_pressed_i, nxt);
        expected_ticks.push_back(nxt);
      end
    end
    fail_count_o <= fails;
    pending_o    <= expected_ticks.size();
  end

endmodule

/* tb/sv/testbench.sv */
// Top of the metronome pulse testbench: clock, reset, button stimulus, register
// phases, output back-pressure, watchdog and verdict. Uses mpb_pkg and
// metronome_checker beside the block under test.
`timescale 1ns / 100ps

module testbench;
  import mpb_pkg::*;

  localparam int LongHold      = 100;
  localparam int WatchdogLimit = 2000;

  logic                clk          = 1'b0;
  logic                rst_n        = 1'b0;
  logic                cfg_we       = 1'b0;
  cfg_idx_e            cfg_idx      = CFG_MIN_TEMPO;
  logic [CfgDataW-1:0] cfg_wdata    = '0;
  logic                in_valid     = 1'b0;
  logic                up_pressed   = 1'b0;
  logic                down_pressed = 1'b0;
  logic                out_stall    = 1'b0;
  logic                hold_req     = 1'b0;
  logic                in_stall;
  logic                out_valid;
  logic                pulse_level;
  logic [7:0]          tempo;
  logic                beat_start;
  int                  fail_count;
  int                  pending;
  int                  idle_cycles  = 0;

  always #5 clk = ~clk;

  metronome_pulse_with_button_rate dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .up_pressed_i   (up_pressed),
    .down_pressed_i (down_pressed),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .pulse_level_o  (pulse_level),
    .tempo_o        (tempo),
    .beat_start_o   (beat_start)
  );

  metronome_checker checker_i (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .up_pressed_i   (up_pressed),
    .down_pressed_i (down_pressed),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .pulse_level_i  (pulse_level),
    .tempo_i        (tempo),
    .beat_start_i   (beat_start),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  // output side back-pressure, with one long hold on request
  initial begin : tick_sink
    int stall_left;
    int run_left;
    int r;
    bit hold_done;
    stall_left = 0;
    run_left   = 0;
    hold_done  = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done  = 1'b1;
        stall_left = LongHold;
        run_left   = 0;
      end else if (stall_left == 0 && run_left == 0) begin
        r = $urandom_range(0, 99);
        if (r < 45)      run_left   = $urandom_range(1, 8);
        else if (r < 55) run_left   = $urandom_range(30, 120);
        else if (r < 92) stall_left = $urandom_range(1, 3);
        else             stall_left = $urandom_range(8, 40);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        run_left--;
      end
    end
  end

  task automatic send_tick(input logic up, input logic down, input int gap);
    in_valid     <= 1'b1;
    up_pressed   <= up;
    down_pressed <= down;
    do @(posedge clk); while (in_stall);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_ticks();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] min_t, input logic [7:0] max_t,
                            input logic [7:0] start_t, input logic [15:0] sub_p,
                            input logic [15:0] pulse_on, input logic [9:0] rep);
    drain_ticks();
    repeat (2) @(posedge clk);
    cfg_write(CFG_MIN_TEMPO, {8'd0, min_t});
    cfg_write(CFG_MAX_TEMPO, {8'd0, max_t});
    cfg_write(CFG_START_TEMPO, {8'd0, start_t});
    cfg_write(CFG_SUB_PERIOD, sub_p);
    cfg_write(CFG_PULSE_ON, pulse_on);
    cfg_write(CFG_REPEAT_INTV, {6'd0, rep});
    cfg_we <= 1'b0;
  endtask

  // button segments: held presses, releases, both held and per-tick noise
  task automatic run_random(input int n_items, input bit no_gaps);
    int   done;
    int   seg_len;
    int   kind;
    int   gap;
    int   r;
    logic up;
    logic down;
    done = 0;
    while (done < n_items) begin
      kind    = $urandom_range(0, 9);
      seg_len = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      for (int k = 0; k < seg_len && done < n_items; k++) begin
        case (kind)
          0, 1, 2, 3: begin up = 1'b1; down = 1'b0; end
          4, 5, 6:    begin up = 1'b0; down = 1'b1; end
          7:          begin up = 1'b0; down = 1'b0; end
          8:          begin up = 1'b1; down = 1'b1; end
          default:    begin
            up   = 1'($urandom_range(0, 1));
            down = 1'($urandom_range(0, 1));
          end
        endcase
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60) gap = 0;
        else if (r < 92)       gap = $urandom_range(1, 3);
        else                   gap = $urandom_range(5, 30);
        send_tick(up, down, gap);
        done++;
      end
    end
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero sub-period, zero pulse drop and zero interval: step every tick
    set_config(8'd40, 8'd240, 8'd200, 16'd0, 16'd0, 10'd0);
    repeat (2)  send_tick(1'b1, 1'b1, 0);
    repeat (12) send_tick(1'b1, 1'b0, 0);
    repeat (3)  send_tick(1'b0, 1'b1, 0);
    repeat (2)  send_tick(1'b1, 1'b1, 0);
    repeat (2)  send_tick(1'b0, 1'b0, 0);

    set_config(8'd1, 8'd255, 8'd120, 16'd1, 16'd1, 10'd1);
    run_random(100, 1'b0);

    // tempo may sit above max here; long output hold while ticks keep coming
    set_config(8'd200, 8'd210, 8'd40, 16'd3, 16'd2, 10'd2);
    run_random(40, 1'b0);
    hold_req <= 1'b1;
    run_random(25, 1'b1);
    drain_ticks();
    run_random(40, 1'b0);

    // min above max: the max clamp is checked first, then the min clamp
    set_config(8'd100, 8'd50, 8'd1, 16'd2, 16'd1, 10'd3);
    run_random(100, 1'b1);

    set_config(8'd1, 8'd1, 8'd255, 16'd60000, 16'd60000, 10'd1023);
    run_random(40, 1'b0);

    // pulse drop beyond the sub-period
    set_config(8'd255, 8'd255, 8'd1, 16'd4, 16'd5, 10'd1);
    run_random(80, 1'b0);

    repeat (3) begin
      set_config(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                 8'($urandom_range(1, 255)), 16'($urandom_range(1, 6)),
                 16'($urandom_range(1, 7)), 10'($urandom_range(1, 6)));
      run_random(100, 1'b0);
    end

    set_config(MinTempoRst, MaxTempoRst, StartTempoRst, SubPeriodRst, PulseOnRst,
               RepeatIntvRst);
    run_random(60, 1'b0);

    drain_ticks();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

/* metronome_pulse_with_button_rate.f */
rtl/mpb_pkg.sv
rtl/mpb_beat.sv
rtl/mpb_tempo.sv
rtl/metronome_pulse_with_button_rate.sv
rtl/mpb_checker.sv
tb/sv/metronome_checker.sv
tb/sv/testbench.sv
